[hdl/hse_pkg.sv]
// ----------------------------------------------------------------------------
// hse_pkg
// Shared sizes for the heap sort engine: store depth and index widths.
// ----------------------------------------------------------------------------
package hse_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int VAL_W  = 32;

   // child index needs one bit more than the element count
   localparam int IDX_W  = CNT_W + 1;

   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CNT_W-1:0]        count_type;

endpackage

[hdl/heap_sort_engine.sv]
// ----------------------------------------------------------------------------
// heap_sort_engine
// Batch heap sort of signed 32-bit values held in one two-read-port store.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one value per item, req_last_item closes the batch. The
//    store keeps up to DEPTH (64) values; later items of the same batch are
//    dropped and the batch is flagged.
//  - after the last item req_ready stays low while the batch is sorted in
//    the store: heap build, then root extraction. One sift level reads both
//    children, then compares and writes back.
//  - rsp_ channel: the batch comes out in ascending order, final flag on the
//    last one, overflow on every result of a flagged batch. Each result
//    goes through a store read, an output load and a handshake; a stalled
//    receiver simply holds the output register.
//  - a new batch is taken after the final result is accepted.
//  - reset empties the batch and returns to loading; store contents are
//    left as they are and never used before being written again.
// ----------------------------------------------------------------------------
module heap_sort_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hse_pkg::value_type  req_value,
   input  logic                req_last_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hse_pkg::value_type  rsp_sorted_value,
   output logic                rsp_final_flag,
   output logic                rsp_overflow
);
   import hse_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_BUILD_RD,
      ST_BUILD_GET,
      ST_SIFT_RD,
      ST_SIFT_CMP,
      ST_SIFT_END,
      ST_EXT_RD,
      ST_EXT_SWAP,
      ST_OUT_RD,
      ST_OUT_LOAD,
      ST_OUT_HOLD
   } state_type;

   state_type state_ff;
   count_type cnt_ff;
   logic      dropped_ff;
   logic      extract_ff;
   count_type par_ff;
   addr_type  ext_ff;
   addr_type  node_ff;
   count_type size_ff;
   value_type cur_ff;
   addr_type  out_idx_ff;
   logic      rsp_valid_ff;
   value_type rsp_value_ff;
   logic      rsp_final_ff;
   logic      rsp_overflow_ff;

   // element store, two read ports with registered data
   value_type store_mem [DEPTH];
   value_type rd_a_ff;
   value_type rd_b_ff;
   logic      mem_we;
   addr_type  mem_wa;
   value_type mem_wd;
   addr_type  ra_a;
   addr_type  ra_b;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= store_mem[ra_a];
      rd_b_ff <= store_mem[ra_b];
   end

   logic       req_fire;
   logic       has_room;
   count_type  cnt_next;
   logic [IDX_W-1:0] l_idx;
   logic [IDX_W-1:0] r_idx;
   logic       l_ok;
   logic       r_ok;
   logic       take_l;
   logic       take_r;
   value_type  big_val;
   logic       out_final;

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign has_room  = (cnt_ff < CNT_W'(DEPTH));
   assign cnt_next  = has_room ? cnt_ff + 1'b1 : cnt_ff;

   assign l_idx = {{(IDX_W-ADDR_W-1){1'b0}}, node_ff, 1'b1};
   assign r_idx = l_idx + 1'b1;
   assign l_ok  = (l_idx < {1'b0, size_ff});
   assign r_ok  = (r_idx < {1'b0, size_ff});

   // pick the larger child, left first as in a swap-based sift
   assign take_l  = (cur_ff < rd_a_ff);
   assign big_val = take_l ? rd_a_ff : cur_ff;
   assign take_r  = r_ok && (big_val < rd_b_ff);

   assign out_final = ((CNT_W'(out_idx_ff) + 1'b1) == cnt_ff);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = node_ff;
      mem_wd = cur_ff;
      ra_a   = l_idx[ADDR_W-1:0];
      ra_b   = r_idx[ADDR_W-1:0];
      case (state_ff)
         ST_LOAD: begin
            mem_we = req_fire && has_room;
            mem_wa = cnt_ff[ADDR_W-1:0];
            mem_wd = req_value;
         end
         ST_BUILD_RD: begin
            ra_a = ADDR_W'(par_ff - 1'b1);
         end
         ST_SIFT_RD: begin
            // bottom reached: drop the moving value into the hole
            mem_we = !l_ok;
         end
         ST_SIFT_CMP: begin
            mem_we = 1'b1;
            if (take_r) begin
               mem_wd = rd_b_ff;
            end else if (take_l) begin
               mem_wd = rd_a_ff;
            end
         end
         ST_EXT_RD: begin
            ra_a = '0;
            ra_b = ext_ff;
         end
         ST_EXT_SWAP: begin
            mem_we = 1'b1;
            mem_wa = ext_ff;
            mem_wd = rd_a_ff;
         end
         ST_OUT_RD: begin
            ra_a = out_idx_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  cnt_ff <= cnt_next;
                  if (!has_room) begin
                     dropped_ff <= 1'b1;
                  end
                  if (req_last_item) begin
                     out_idx_ff <= '0;
                     extract_ff <= 1'b0;
                     par_ff     <= cnt_next >> 1;
                     if (cnt_next < CNT_W'(2)) begin
                        state_ff <= ST_OUT_RD;
                     end else begin
                        state_ff <= ST_BUILD_RD;
                     end
                  end
               end
            end
            ST_BUILD_RD: begin
               state_ff <= ST_BUILD_GET;
            end
            ST_BUILD_GET: begin
               cur_ff   <= rd_a_ff;
               node_ff  <= ADDR_W'(par_ff - 1'b1);
               size_ff  <= cnt_ff;
               state_ff <= ST_SIFT_RD;
            end
            ST_SIFT_RD: begin
               state_ff <= l_ok ? ST_SIFT_CMP : ST_SIFT_END;
            end
            ST_SIFT_CMP: begin
               if (take_r) begin
                  node_ff  <= r_idx[ADDR_W-1:0];
                  state_ff <= ST_SIFT_RD;
               end else if (take_l) begin
                  node_ff  <= l_idx[ADDR_W-1:0];
                  state_ff <= ST_SIFT_RD;
               end else begin
                  state_ff <= ST_SIFT_END;
               end
            end
            ST_SIFT_END: begin
               if (!extract_ff) begin
                  if (par_ff > CNT_W'(1)) begin
                     par_ff   <= par_ff - 1'b1;
                     state_ff <= ST_BUILD_RD;
                  end else begin
                     extract_ff <= 1'b1;
                     ext_ff     <= ADDR_W'(cnt_ff - 1'b1);
                     state_ff   <= ST_EXT_RD;
                  end
               end else if (ext_ff > ADDR_W'(1)) begin
                  ext_ff   <= ext_ff - 1'b1;
                  state_ff <= ST_EXT_RD;
               end else begin
                  state_ff <= ST_OUT_RD;
               end
            end
            ST_EXT_RD: begin
               state_ff <= ST_EXT_SWAP;
            end
            ST_EXT_SWAP: begin
               // old root goes to the end, old end value sifts from the root
               cur_ff   <= rd_b_ff;
               node_ff  <= '0;
               size_ff  <= CNT_W'(ext_ff);
               state_ff <= ST_SIFT_RD;
            end
            ST_OUT_RD: begin
               state_ff <= ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
               rsp_valid_ff    <= 1'b1;
               rsp_value_ff    <= rd_a_ff;
               rsp_final_ff    <= out_final;
               rsp_overflow_ff <= dropped_ff;
               state_ff        <= ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_final_ff) begin
                     cnt_ff     <= '0;
                     dropped_ff <= 1'b0;
                     state_ff   <= ST_LOAD;
                  end else begin
                     out_idx_ff <= out_idx_ff + 1'b1;
                     state_ff   <= ST_OUT_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_final_flag   = rsp_final_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   a_valid_only_in_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_OUT_HOLD))
      else $error("result valid outside output hold");

   a_no_load_during_output: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("loading while a result is pending");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("element count above store depth");

   a_batch_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final_flag) |=>
         (cnt_ff == '0) && !dropped_ff && req_ready)
      else $error("batch not cleared after final result");

endmodule
